// File: rtl/core/agpf_pkg.sv
// shared constants, codes and control types of the gabor pixel filter
package agpf_pkg;

    localparam int IMG_ROWS   = 256;
    localparam int IMG_COLS   = 256;
    localparam int NUM_FREQ   = 8;
    localparam int NUM_ORIENT = 16;
    localparam int MAX_K      = 16;

    localparam int NUM_CLS = NUM_FREQ * NUM_ORIENT;
    localparam int ROW_W   = $clog2(IMG_ROWS);
    localparam int COL_W   = $clog2(IMG_COLS);
    localparam int PIX_AW  = $clog2(IMG_ROWS * IMG_COLS);
    localparam int CLS_W   = $clog2(NUM_CLS);
    localparam int TAP_W   = $clog2(MAX_K);
    localparam int K_W     = $clog2(MAX_K + 1);
    localparam int COEF_AW = $clog2(NUM_CLS * MAX_K * MAX_K);

    // fixed field widths
    localparam int CMD_W     = 2;
    localparam int IN_ROW_W  = 8;
    localparam int IN_COL_W  = 8;
    localparam int FREQ_W    = 3;
    localparam int ORIENT_W  = 4;
    localparam int IN_TAP_W  = 4;
    localparam int DATA_W    = 8;
    localparam int OUT_W     = 22;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;

    localparam int PIX_W    = 7;
    localparam int COEF_W   = 7;
    localparam int PROD_W   = PIX_W + 1 + COEF_W;
    localparam int SUM_BITS = PROD_W + 2 * TAP_W;
    localparam int ACC_W    = (SUM_BITS > OUT_W) ? SUM_BITS : OUT_W;

    localparam int PIX_MAX  = 100;
    localparam int COEF_MIN = -46;
    localparam int COEF_MAX = 54;
    localparam int SUM_MAX  = 2097151;
    localparam int SUM_MIN  = -2097152;

    localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

    localparam logic [CMD_W-1:0] CMD_WR_PIXEL = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WR_COEF  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WR_KSIZE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FILTER   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd1;

    typedef struct packed {
        logic write;
        logic load;
        logic step;
        logic finish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic last_tap;
        logic pipe_busy;
    } t_dp_status;

endpackage

// File: rtl/core/agpf_ctrl.sv
// controller state machine: command acceptance, tap sweep and drain
module agpf_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    input  logic [agpf_pkg::CMD_W-1:0]   i_cmd,
    input  agpf_pkg::t_dp_status         i_status,
    output agpf_pkg::t_ctrl_cmd          o_ctrl,
    output logic                         busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_ctrl  = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd == agpf_pkg::CMD_FILTER) begin
                        o_ctrl.load = 1'b1;
                        n_state     = S_RUN;
                    end else begin
                        o_ctrl.write = 1'b1;
                    end
                end
            end
            S_RUN: begin
                o_ctrl.step = 1'b1;
                if (i_status.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_status.pipe_busy) begin
                    o_ctrl.finish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

// File: rtl/core/agpf_dp.sv
// datapath: stores, window address generation, multiply-accumulate, result register
module agpf_dp (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  agpf_pkg::t_ctrl_cmd                  i_ctrl,
    output agpf_pkg::t_dp_status                 o_status,
    input  logic [agpf_pkg::CMD_W-1:0]           i_cmd,
    input  logic [agpf_pkg::IN_ROW_W-1:0]        i_row,
    input  logic [agpf_pkg::IN_COL_W-1:0]        i_col,
    input  logic [agpf_pkg::FREQ_W-1:0]          i_freq_index,
    input  logic [agpf_pkg::ORIENT_W-1:0]        i_orient_index,
    input  logic [agpf_pkg::IN_TAP_W-1:0]        i_tap_row,
    input  logic [agpf_pkg::IN_TAP_W-1:0]        i_tap_col,
    input  logic signed [agpf_pkg::DATA_W-1:0]   i_data,
    input  logic                                 i_cfg_we,
    input  logic [agpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [agpf_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [agpf_pkg::OUT_W-1:0]    o_filtered_value,
    output logic [agpf_pkg::IN_ROW_W-1:0]        o_out_row,
    output logic [agpf_pkg::IN_COL_W-1:0]        o_out_col
);

    localparam int RE_W = ((agpf_pkg::ROW_W > agpf_pkg::TAP_W) ?
                           agpf_pkg::ROW_W : agpf_pkg::TAP_W) + 2;
    localparam int CE_W = ((agpf_pkg::COL_W > agpf_pkg::TAP_W) ?
                           agpf_pkg::COL_W : agpf_pkg::TAP_W) + 2;

    // stores
    logic [agpf_pkg::PIX_W-1:0]         pix_mem  [agpf_pkg::IMG_ROWS*agpf_pkg::IMG_COLS];
    logic signed [agpf_pkg::COEF_W-1:0] coef_mem [agpf_pkg::NUM_CLS*agpf_pkg::MAX_K*agpf_pkg::MAX_K];
    logic [agpf_pkg::K_W-1:0]           ks_mem   [agpf_pkg::NUM_CLS];

    logic [agpf_pkg::CFG_W-1:0]         r_height;
    logic [agpf_pkg::CFG_W-1:0]         r_width;

    logic [agpf_pkg::IN_ROW_W-1:0]      r_row;
    logic [agpf_pkg::IN_COL_W-1:0]      r_col;
    logic [agpf_pkg::CLS_W-1:0]         r_cls;
    logic                               r_cls_ok;
    logic [agpf_pkg::K_W-1:0]           r_ks_q;
    logic [agpf_pkg::TAP_W-1:0]         r_tr;
    logic [agpf_pkg::TAP_W-1:0]         r_tc;

    logic [agpf_pkg::PIX_W-1:0]         r_pix_q;
    logic signed [agpf_pkg::COEF_W-1:0] r_coef_q;
    logic                               r_v1;
    logic signed [agpf_pkg::PROD_W-1:0] r_prod;
    logic                               r_v2;
    logic signed [agpf_pkg::ACC_W-1:0]  r_acc;

    logic                               r_out_valid;
    logic signed [agpf_pkg::OUT_W-1:0]  r_out_value;
    logic [agpf_pkg::IN_ROW_W-1:0]      r_out_row;
    logic [agpf_pkg::IN_COL_W-1:0]      r_out_col;

    logic [agpf_pkg::CLS_W-1:0]         in_cls;
    logic                               in_cls_ok;
    logic                               pix_ok;
    logic                               coef_ok;
    logic [agpf_pkg::PIX_AW-1:0]        pix_waddr;
    logic [agpf_pkg::COEF_AW-1:0]       coef_waddr;
    logic [agpf_pkg::PIX_W-1:0]         pix_wdata;
    logic signed [agpf_pkg::COEF_W-1:0] coef_wdata;
    logic [agpf_pkg::K_W-1:0]           ks_wdata;

    logic [agpf_pkg::K_W-1:0]           half;
    logic [agpf_pkg::K_W-1:0]           km1;
    logic [agpf_pkg::ROW_W-1:0]         hm1;
    logic [agpf_pkg::COL_W-1:0]         wm1;
    logic signed [RE_W-1:0]             pr_e;
    logic signed [CE_W-1:0]             pc_e;
    logic [agpf_pkg::ROW_W-1:0]         pr;
    logic [agpf_pkg::COL_W-1:0]         pc;
    logic [agpf_pkg::PIX_AW-1:0]        pix_raddr;
    logic [agpf_pkg::COEF_AW-1:0]       coef_raddr;
    logic                               tc_wrap;
    logic signed [agpf_pkg::OUT_W-1:0]  sat_value;

    // write side decode and saturation
    always_comb begin
        in_cls    = agpf_pkg::CLS_W'(i_freq_index) * agpf_pkg::CLS_W'(agpf_pkg::NUM_ORIENT)
                    + agpf_pkg::CLS_W'(i_orient_index);
        in_cls_ok = (32'(i_freq_index) < agpf_pkg::NUM_FREQ) &&
                    (32'(i_orient_index) < agpf_pkg::NUM_ORIENT);
        pix_ok    = (32'(i_row) < agpf_pkg::IMG_ROWS) && (32'(i_col) < agpf_pkg::IMG_COLS);
        coef_ok   = in_cls_ok && (32'(i_tap_row) < agpf_pkg::MAX_K) &&
                    (32'(i_tap_col) < agpf_pkg::MAX_K);
        pix_waddr = agpf_pkg::PIX_AW'(i_row) * agpf_pkg::PIX_AW'(agpf_pkg::IMG_COLS)
                    + agpf_pkg::PIX_AW'(i_col);
        coef_waddr = agpf_pkg::COEF_AW'(in_cls)
                         * agpf_pkg::COEF_AW'(agpf_pkg::MAX_K * agpf_pkg::MAX_K)
                     + agpf_pkg::COEF_AW'(i_tap_row) * agpf_pkg::COEF_AW'(agpf_pkg::MAX_K)
                     + agpf_pkg::COEF_AW'(i_tap_col);

        if (i_data < 0) begin
            pix_wdata = '0;
        end else if (i_data > agpf_pkg::PIX_MAX) begin
            pix_wdata = agpf_pkg::PIX_W'(agpf_pkg::PIX_MAX);
        end else begin
            pix_wdata = agpf_pkg::PIX_W'(i_data);
        end

        if (i_data < agpf_pkg::COEF_MIN) begin
            coef_wdata = agpf_pkg::COEF_W'(agpf_pkg::COEF_MIN);
        end else if (i_data > agpf_pkg::COEF_MAX) begin
            coef_wdata = agpf_pkg::COEF_W'(agpf_pkg::COEF_MAX);
        end else begin
            coef_wdata = agpf_pkg::COEF_W'(i_data);
        end

        if (i_data < 1) begin
            ks_wdata = agpf_pkg::K_W'(1);
        end else if (i_data > agpf_pkg::MAX_K) begin
            ks_wdata = agpf_pkg::K_W'(agpf_pkg::MAX_K);
        end else begin
            ks_wdata = agpf_pkg::K_W'(i_data);
        end
    end

    // clamp limits from the image size registers
    always_comb begin
        if (r_height == '0) begin
            hm1 = '0;
        end else if (32'(r_height) > agpf_pkg::IMG_ROWS) begin
            hm1 = agpf_pkg::ROW_W'(agpf_pkg::IMG_ROWS - 1);
        end else begin
            hm1 = agpf_pkg::ROW_W'(r_height - 1'b1);
        end
        if (r_width == '0) begin
            wm1 = '0;
        end else if (32'(r_width) > agpf_pkg::IMG_COLS) begin
            wm1 = agpf_pkg::COL_W'(agpf_pkg::IMG_COLS - 1);
        end else begin
            wm1 = agpf_pkg::COL_W'(r_width - 1'b1);
        end
    end

    // window address of the current tap
    always_comb begin
        half = r_ks_q >> 1;
        km1  = r_ks_q - 1'b1;
        pr_e = $signed(RE_W'(r_row)) + $signed(RE_W'(r_tr)) - $signed(RE_W'(half));
        pc_e = $signed(CE_W'(r_col)) + $signed(CE_W'(r_tc)) - $signed(CE_W'(half));

        if (pr_e < 0) begin
            pr = '0;
        end else if (pr_e > $signed(RE_W'(hm1))) begin
            pr = hm1;
        end else begin
            pr = agpf_pkg::ROW_W'(pr_e);
        end
        if (pc_e < 0) begin
            pc = '0;
        end else if (pc_e > $signed(CE_W'(wm1))) begin
            pc = wm1;
        end else begin
            pc = agpf_pkg::COL_W'(pc_e);
        end

        pix_raddr  = agpf_pkg::PIX_AW'(pr) * agpf_pkg::PIX_AW'(agpf_pkg::IMG_COLS)
                     + agpf_pkg::PIX_AW'(pc);
        coef_raddr = agpf_pkg::COEF_AW'(r_cls)
                         * agpf_pkg::COEF_AW'(agpf_pkg::MAX_K * agpf_pkg::MAX_K)
                     + agpf_pkg::COEF_AW'(r_tr) * agpf_pkg::COEF_AW'(agpf_pkg::MAX_K)
                     + agpf_pkg::COEF_AW'(r_tc);

        tc_wrap  = (agpf_pkg::K_W'(r_tc) == km1);
        o_status.last_tap  = tc_wrap && (agpf_pkg::K_W'(r_tr) == km1);
        o_status.pipe_busy = r_v1 | r_v2;
    end

    always_comb begin
        if (!r_cls_ok) begin
            sat_value = '0;
        end else if (r_acc > agpf_pkg::ACC_W'(agpf_pkg::SUM_MAX)) begin
            sat_value = agpf_pkg::OUT_W'(agpf_pkg::SUM_MAX);
        end else if (r_acc < agpf_pkg::ACC_W'(agpf_pkg::SUM_MIN)) begin
            sat_value = agpf_pkg::OUT_W'(agpf_pkg::SUM_MIN);
        end else begin
            sat_value = agpf_pkg::OUT_W'(r_acc);
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && i_cmd == agpf_pkg::CMD_WR_PIXEL && pix_ok) begin
            pix_mem[pix_waddr] <= pix_wdata;
        end
        if (i_ctrl.step) begin
            r_pix_q <= pix_mem[pix_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && i_cmd == agpf_pkg::CMD_WR_COEF && coef_ok) begin
            coef_mem[coef_waddr] <= coef_wdata;
        end
        if (i_ctrl.step) begin
            r_coef_q <= coef_mem[coef_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.write && i_cmd == agpf_pkg::CMD_WR_KSIZE && in_cls_ok) begin
            ks_mem[in_cls] <= ks_wdata;
        end
        if (i_ctrl.load) begin
            r_ks_q <= ks_mem[in_cls];
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= agpf_pkg::CFG_RESET;
            r_width  <= agpf_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                agpf_pkg::REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                agpf_pkg::REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // command capture and tap counters
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_row    <= i_row;
            r_col    <= i_col;
            r_cls    <= in_cls;
            r_cls_ok <= in_cls_ok;
            r_tr     <= '0;
            r_tc     <= '0;
        end else if (i_ctrl.step) begin
            if (tc_wrap) begin
                r_tc <= '0;
                r_tr <= r_tr + 1'b1;
            end else begin
                r_tc <= r_tc + 1'b1;
            end
        end
    end

    // read, multiply and accumulate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_ctrl.step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= $signed({1'b0, r_pix_q}) * r_coef_q;
        if (i_ctrl.load) begin
            r_acc <= '0;
        end else if (r_v2) begin
            r_acc <= r_acc + agpf_pkg::ACC_W'(r_prod);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctrl.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.finish) begin
            r_out_value <= sat_value;
            r_out_row   <= r_row;
            r_out_col   <= r_col;
        end
    end

    assign o_strobe         = r_out_valid;
    assign o_filtered_value = r_out_value;
    assign o_out_row        = r_out_row;
    assign o_out_col        = r_out_col;

endmodule

// File: rtl/core/adaptive_gabor_pixel_filter_top.sv
// top level of the gabor pixel filter: controller plus datapath
// write commands leave busy low and no result follows
// a filter command with kernel size k holds busy through sweep and drain; the sweep issues
// one tap a cycle from the pixel and coefficient memories, then the mac pipe drains
// the result strobe is registered at the end of the drain and shows for one cycle, unstalled
// synchronous active-low reset clears control and sets image size to 256; stores are kept
module adaptive_gabor_pixel_filter_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [agpf_pkg::CMD_W-1:0]           i_cmd,
    input  logic [agpf_pkg::IN_ROW_W-1:0]        i_row,
    input  logic [agpf_pkg::IN_COL_W-1:0]        i_col,
    input  logic [agpf_pkg::FREQ_W-1:0]          i_freq_index,
    input  logic [agpf_pkg::ORIENT_W-1:0]        i_orient_index,
    input  logic [agpf_pkg::IN_TAP_W-1:0]        i_tap_row,
    input  logic [agpf_pkg::IN_TAP_W-1:0]        i_tap_col,
    input  logic signed [agpf_pkg::DATA_W-1:0]   i_data,
    input  logic                                 i_cfg_we,
    input  logic [agpf_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [agpf_pkg::CFG_W-1:0]           i_cfg_data,
    output logic                                 o_strobe,
    output logic signed [agpf_pkg::OUT_W-1:0]    o_filtered_value,
    output logic [agpf_pkg::IN_ROW_W-1:0]        o_out_row,
    output logic [agpf_pkg::IN_COL_W-1:0]        o_out_col
);

    agpf_pkg::t_ctrl_cmd  ctrl;
    agpf_pkg::t_dp_status status;

    agpf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .i_status (status),
        .o_ctrl   (ctrl),
        .busy     (busy)
    );

    agpf_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctrl           (ctrl),
        .o_status         (status),
        .i_cmd            (i_cmd),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_freq_index     (i_freq_index),
        .i_orient_index   (i_orient_index),
        .i_tap_row        (i_tap_row),
        .i_tap_col        (i_tap_col),
        .i_data           (i_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_filtered_value (o_filtered_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col)
    );

endmodule

// File: rtl/core/agpf_checker.sv
// port-level checker for the gabor pixel filter, bound to the top level
module agpf_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic [agpf_pkg::CMD_W-1:0]  i_cmd,
    input logic                        o_strobe
);

    // a filter transfer always makes the block busy
    a_filter_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd == agpf_pkg::CMD_FILTER) |=> busy)
        else $error("filter transfer did not raise busy");

    // write transfers leave the block idle
    a_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_cmd != agpf_pkg::CMD_FILTER) |=> !busy)
        else $error("write transfer raised busy");

    // each result shows for one cycle only
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    // end of a filter run always delivers its result
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> o_strobe)
        else $error("busy dropped without a result");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result strobe while busy");

endmodule

bind adaptive_gabor_pixel_filter_top agpf_checker u_agpf_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe)
);

// File: bench/tb_adaptive_gabor_pixel_filter_top.sv
`timescale 1ns / 1ps
// self-checking testbench for the gabor pixel filter: predicted window sums against the block
module tb_adaptive_gabor_pixel_filter_top;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int TOTAL_ITEMS     = 1000;
    localparam int MIN_PHASE_ITEMS = 20;
    localparam int PHASES          = 8;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = agpf_pkg::MAX_K * agpf_pkg::MAX_K + 8;
    localparam longint TIMEOUT_NS  = 40_000_000;

    localparam int FILL_RANDOM = 0;
    localparam int FILL_HIGH   = 1;
    localparam int FILL_LOW    = 2;

    localparam int PIX_DEPTH  = agpf_pkg::IMG_ROWS * agpf_pkg::IMG_COLS;
    localparam int COEF_DEPTH = agpf_pkg::NUM_CLS * agpf_pkg::MAX_K * agpf_pkg::MAX_K;

    typedef struct packed {
        logic [agpf_pkg::CMD_W-1:0]         cmd;
        logic [agpf_pkg::IN_ROW_W-1:0]      row;
        logic [agpf_pkg::IN_COL_W-1:0]      col;
        logic [agpf_pkg::FREQ_W-1:0]        freq;
        logic [agpf_pkg::ORIENT_W-1:0]      orient;
        logic [agpf_pkg::IN_TAP_W-1:0]      tap_row;
        logic [agpf_pkg::IN_TAP_W-1:0]      tap_col;
        logic signed [agpf_pkg::DATA_W-1:0] data;
    } t_filter_cmd;

    typedef struct packed {
        logic signed [agpf_pkg::OUT_W-1:0] sum;
        logic [agpf_pkg::IN_ROW_W-1:0]     row;
        logic [agpf_pkg::IN_COL_W-1:0]     col;
    } t_window_result;

    class gabor_scoreboard;
        bit [agpf_pkg::PIX_W-1:0]         pixel_mem [PIX_DEPTH];
        bit signed [agpf_pkg::COEF_W-1:0] coef_mem [COEF_DEPTH];
        bit [agpf_pkg::K_W-1:0]           ksize_mem [agpf_pkg::NUM_CLS];
        int height;
        int width;
        t_window_result pending_sums [$];
        int error_count;
        int sums_checked;

        function new();
            height = agpf_pkg::IMG_ROWS;
            width = agpf_pkg::IMG_COLS;
        endfunction

        function void set_geometry(logic [agpf_pkg::CFG_IDX_W-1:0] idx,
                                   logic [agpf_pkg::CFG_W-1:0] value);
            if (idx == agpf_pkg::REG_IMAGE_HEIGHT) begin
                height = int'(value);
            end else begin
                width = int'(value);
            end
        endfunction

        function int clamp(int v, int lo, int hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        function int class_of(int fi, int oi);
            return fi * agpf_pkg::NUM_ORIENT + oi;
        endfunction

        function int coef_addr(int cls, int r, int c);
            return (cls * agpf_pkg::MAX_K + r) * agpf_pkg::MAX_K + c;
        endfunction

        // window tap to image address, clamped into the image in use
        function int pixel_addr(int row, int col, int r, int c, int k);
            int h;
            int w;
            int pr;
            int pc;
            h = clamp(height, 1, agpf_pkg::IMG_ROWS);
            w = clamp(width, 1, agpf_pkg::IMG_COLS);
            pr = clamp(row + r - k / 2, 0, h - 1);
            pc = clamp(col + c - k / 2, 0, w - 1);
            return pr * agpf_pkg::IMG_COLS + pc;
        endfunction

        function int window_sum(t_filter_cmd t);
            int cls;
            int k;
            int acc;
            cls = class_of(int'(t.freq), int'(t.orient));
            k = int'(ksize_mem[cls]);
            acc = 0;
            for (int r = 0; r < k; r++) begin
                for (int c = 0; c < k; c++) begin
                    acc += int'(pixel_mem[pixel_addr(int'(t.row), int'(t.col), r, c, k)])
                         * int'(coef_mem[coef_addr(cls, r, c)]);
                end
            end
            return clamp(acc, agpf_pkg::SUM_MIN, agpf_pkg::SUM_MAX);
        endfunction

        function void note_command(t_filter_cmd t);
            int cls;
            int d;
            t_window_result res;
            cls = class_of(int'(t.freq), int'(t.orient));
            d = int'(t.data);
            case (t.cmd)
                agpf_pkg::CMD_WR_PIXEL: pixel_mem[{t.row, t.col}] =
                    agpf_pkg::PIX_W'(clamp(d, 0, agpf_pkg::PIX_MAX));
                agpf_pkg::CMD_WR_COEF: coef_mem[coef_addr(cls, int'(t.tap_row),
                                                          int'(t.tap_col))] =
                    agpf_pkg::COEF_W'(clamp(d, agpf_pkg::COEF_MIN, agpf_pkg::COEF_MAX));
                agpf_pkg::CMD_WR_KSIZE: ksize_mem[cls] =
                    agpf_pkg::K_W'(clamp(d, 1, agpf_pkg::MAX_K));
                agpf_pkg::CMD_FILTER: begin
                    res.sum = agpf_pkg::OUT_W'(window_sum(t));
                    res.row = t.row;
                    res.col = t.col;
                    pending_sums.push_back(res);
                end
                default: begin
                end
            endcase
        endfunction

        function void flag(string what, int want, int got);
            $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            error_count++;
        endfunction

        function void check_result(logic signed [agpf_pkg::OUT_W-1:0] sum,
                                   logic [agpf_pkg::IN_ROW_W-1:0] row,
                                   logic [agpf_pkg::IN_COL_W-1:0] col);
            t_window_result want;
            if (pending_sums.size() == 0) begin
                flag("unrequested result, filtered_value", 0, int'(sum));
                return;
            end
            want = pending_sums.pop_front();
            sums_checked++;
            if (sum !== want.sum) flag("filtered_value", int'(want.sum), int'(sum));
            if (row !== want.row) flag("out_row", int'(want.row), int'(row));
            if (col !== want.col) flag("out_col", int'(want.col), int'(col));
        endfunction
    endclass

    logic                                 i_clk = 1'b0;
    logic                                 i_rst_n = 1'b0;
    logic                                 start = 1'b0;
    logic                                 busy;
    logic [agpf_pkg::CMD_W-1:0]           i_cmd = '0;
    logic [agpf_pkg::IN_ROW_W-1:0]        i_row = '0;
    logic [agpf_pkg::IN_COL_W-1:0]        i_col = '0;
    logic [agpf_pkg::FREQ_W-1:0]          i_freq_index = '0;
    logic [agpf_pkg::ORIENT_W-1:0]        i_orient_index = '0;
    logic [agpf_pkg::IN_TAP_W-1:0]        i_tap_row = '0;
    logic [agpf_pkg::IN_TAP_W-1:0]        i_tap_col = '0;
    logic signed [agpf_pkg::DATA_W-1:0]   i_data = '0;
    logic                                 i_cfg_we = 1'b0;
    logic [agpf_pkg::CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [agpf_pkg::CFG_W-1:0]           i_cfg_data = '0;
    logic                                 o_strobe;
    logic signed [agpf_pkg::OUT_W-1:0]    o_filtered_value;
    logic [agpf_pkg::IN_ROW_W-1:0]        o_out_row;
    logic [agpf_pkg::IN_COL_W-1:0]        o_out_col;

    gabor_scoreboard sb;
    bit pix_written [PIX_DEPTH];
    bit coef_written [COEF_DEPTH];
    bit ksize_written [agpf_pkg::NUM_CLS];
    bit idling_on;
    int fill_mode;
    int cmds_sent;
    int geometry_writes;

    adaptive_gabor_pixel_filter_top DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_cmd            (i_cmd),
        .i_row            (i_row),
        .i_col            (i_col),
        .i_freq_index     (i_freq_index),
        .i_orient_index   (i_orient_index),
        .i_tap_row        (i_tap_row),
        .i_tap_col        (i_tap_col),
        .i_data           (i_data),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_strobe         (o_strobe),
        .o_filtered_value (o_filtered_value),
        .o_out_row        (o_out_row),
        .o_out_col        (o_out_col)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            sb.check_result(o_filtered_value, o_out_row, o_out_col);
        end
    end

    function automatic t_filter_cmd cmd_item(logic [agpf_pkg::CMD_W-1:0] cmd, int row,
                                             int col, int fi, int oi, int tr, int tc,
                                             logic [7:0] data);
        t_filter_cmd t;
        t.cmd = cmd;
        t.row = agpf_pkg::IN_ROW_W'(row);
        t.col = agpf_pkg::IN_COL_W'(col);
        t.freq = agpf_pkg::FREQ_W'(fi);
        t.orient = agpf_pkg::ORIENT_W'(oi);
        t.tap_row = agpf_pkg::IN_TAP_W'(tr);
        t.tap_col = agpf_pkg::IN_TAP_W'(tc);
        t.data = $signed(data);
        return t;
    endfunction

    function automatic logic [7:0] pixel_data();
        if ($urandom_range(0, 9) < 7) return 8'($urandom_range(0, agpf_pkg::PIX_MAX));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] coef_data();
        int v;
        v = int'($urandom_range(0, agpf_pkg::COEF_MAX - agpf_pkg::COEF_MIN))
            + agpf_pkg::COEF_MIN;
        if ($urandom_range(0, 9) < 7) return v[7:0];
        return 8'($urandom_range(0, 255));
    endfunction

    // mostly small kernels, now and then a negative or zero byte that saturates to one
    function automatic logic [7:0] ksize_data();
        int pick;
        pick = int'($urandom_range(0, 19));
        if (pick < 13) return 8'($urandom_range(1, 3));
        if (pick < 17) return 8'($urandom_range(4, 6));
        if (pick < 18) return 8'($urandom_range(7, 10));
        return $urandom_range(0, 1) != 0 ? 8'($urandom_range(128, 255)) : 8'h00;
    endfunction

    function automatic logic [7:0] pixel_fill();
        return fill_mode == FILL_RANDOM ? pixel_data() : 8'h7F;
    endfunction

    function automatic logic [7:0] coef_fill();
        if (fill_mode == FILL_HIGH) return 8'h7F;
        if (fill_mode == FILL_LOW) return 8'h80;
        return coef_data();
    endfunction

    // corners and a middle patch, so windows overlap and reuse written pixels
    function automatic int hot_coord();
        case ($urandom_range(0, 2))
            0: return int'($urandom_range(0, 11));
            1: return int'($urandom_range(244, 255));
            default: return int'($urandom_range(122, 133));
        endcase
    endfunction

    task automatic send_cmd(t_filter_cmd t);
        if (idling_on && $urandom_range(0, 4) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= t.cmd;
        i_row <= t.row;
        i_col <= t.col;
        i_freq_index <= t.freq;
        i_orient_index <= t.orient;
        i_tap_row <= t.tap_row;
        i_tap_col <= t.tap_col;
        i_data <= t.data;
        do @(posedge i_clk); while (busy !== 1'b0);
        // start stays high; the caller either sends again or lowers it
        sb.note_command(t);
        cmds_sent++;
        case (t.cmd)
            agpf_pkg::CMD_WR_PIXEL: pix_written[{t.row, t.col}] = 1'b1;
            agpf_pkg::CMD_WR_COEF: coef_written[sb.coef_addr(
                sb.class_of(int'(t.freq), int'(t.orient)),
                int'(t.tap_row), int'(t.tap_col))] = 1'b1;
            agpf_pkg::CMD_WR_KSIZE:
                ksize_written[sb.class_of(int'(t.freq), int'(t.orient))] = 1'b1;
            default: ;
        endcase
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (sb.pending_sums.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_geometry(logic [agpf_pkg::CFG_IDX_W-1:0] idx,
                                  logic [agpf_pkg::CFG_W-1:0] value);
        wait_all_results();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_geometry(idx, value);
        geometry_writes++;
    endtask

    // write every store entry the filter will read that holds nothing yet, then filter
    task automatic prime_and_filter(int row, int col, int fi, int oi);
        int cls;
        int k;
        int a;
        cls = sb.class_of(fi, oi);
        if (!ksize_written[cls]) begin
            send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, $urandom_range(0, 255),
                              $urandom_range(0, 255), fi, oi, $urandom_range(0, 15),
                              $urandom_range(0, 15), ksize_data()));
        end
        k = int'(sb.ksize_mem[cls]);
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < k; c++) begin
                if (!coef_written[sb.coef_addr(cls, r, c)]) begin
                    send_cmd(cmd_item(agpf_pkg::CMD_WR_COEF, $urandom_range(0, 255),
                                      $urandom_range(0, 255), fi, oi, r, c, coef_fill()));
                end
            end
        end
        for (int r = 0; r < k; r++) begin
            for (int c = 0; c < k; c++) begin
                a = sb.pixel_addr(row, col, r, c, k);
                if (!pix_written[a]) begin
                    send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, a / agpf_pkg::IMG_COLS,
                                      a % agpf_pkg::IMG_COLS,
                                      $urandom_range(0, 7), $urandom_range(0, 15),
                                      $urandom_range(0, 15), $urandom_range(0, 15),
                                      pixel_fill()));
                end
            end
        end
        send_cmd(cmd_item(agpf_pkg::CMD_FILTER, row, col, fi, oi, $urandom_range(0, 15),
                          $urandom_range(0, 15), 8'($urandom_range(0, 255))));
    endtask

    task automatic directed_checks();
        // largest sum: all-max pixels and coefficients under a full kernel at the far corner
        fill_mode = FILL_HIGH;
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 7, 15, 0, 0, 8'h7F));
        prime_and_filter(255, 255, 7, 15);
        // most negative sum over the same corner pixels
        fill_mode = FILL_LOW;
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 0, 0, 0, 0, 8'd17));
        prime_and_filter(255, 255, 0, 0);
        fill_mode = FILL_RANDOM;
        // saturation of written data
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 1, 2, 0, 0, 8'h00));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, 128, 128, 0, 0, 0, 0, 8'h80));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, 128, 129, 0, 0, 0, 0, 8'h7F));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, 127, 128, 0, 0, 0, 0, 8'hFF));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, 129, 128, 0, 0, 0, 0, 8'd101));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_COEF, 0, 0, 1, 2, 0, 0, 8'd55));
        prime_and_filter(128, 128, 1, 2);
        send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, 128, 128, 0, 0, 0, 0, 8'd100));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_COEF, 0, 0, 1, 2, 0, 0, 8'hD1));
        prime_and_filter(128, 128, 1, 2);
        send_cmd(cmd_item(agpf_pkg::CMD_WR_COEF, 0, 0, 5, 9, 15, 15, 8'h80));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_COEF, 0, 0, 5, 9, 15, 0, 8'h7F));
        // even kernel, then a size written twice with a negative byte first
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 2, 3, 0, 0, 8'd4));
        prime_and_filter(0, 255, 2, 3);
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 3, 4, 0, 0, 8'hFF));
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 3, 4, 0, 0, 8'd5));
        prime_and_filter(255, 0, 3, 4);
        send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, 0, 0, 4, 5, 0, 0, 8'd3));
        prime_and_filter(130, 126, 4, 5);
    endtask

    task automatic random_phase(int count);
        int op;
        int row;
        int col;
        int fi;
        int oi;
        int stop;
        stop = cmds_sent + count;
        while (cmds_sent < stop) begin
            op = int'($urandom_range(0, 99));
            if (op < 35) begin
                row = $urandom_range(0, 6) != 0 ? hot_coord() : int'($urandom_range(0, 255));
                col = $urandom_range(0, 6) != 0 ? hot_coord() : int'($urandom_range(0, 255));
                // most filters reuse a small set of kernel classes
                if ($urandom_range(0, 3) != 0) begin
                    fi = int'($urandom_range(4, 5));
                    oi = int'($urandom_range(0, 3));
                end else begin
                    fi = int'($urandom_range(0, 7));
                    oi = int'($urandom_range(0, 15));
                end
                prime_and_filter(row, col, fi, oi);
            end else if (op < 65) begin
                row = $urandom_range(0, 1) != 0 ? hot_coord() : int'($urandom_range(0, 255));
                col = $urandom_range(0, 1) != 0 ? hot_coord() : int'($urandom_range(0, 255));
                send_cmd(cmd_item(agpf_pkg::CMD_WR_PIXEL, row, col, $urandom_range(0, 7),
                                  $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 15), pixel_data()));
            end else if (op < 85) begin
                send_cmd(cmd_item(agpf_pkg::CMD_WR_COEF, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 7),
                                  $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 15), coef_data()));
            end else begin
                send_cmd(cmd_item(agpf_pkg::CMD_WR_KSIZE, $urandom_range(0, 255),
                                  $urandom_range(0, 255), $urandom_range(0, 7),
                                  $urandom_range(0, 15), $urandom_range(0, 15),
                                  $urandom_range(0, 15), ksize_data()));
            end
            // now and then hold off until the block has delivered everything
            if ($urandom_range(0, 59) == 0) wait_all_results();
        end
    endtask

    initial begin
        int phase_items;
        sb = new();
        idling_on = 1'b0;
        fill_mode = FILL_RANDOM;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, agpf_pkg::CFG_RESET);
        write_geometry(agpf_pkg::REG_IMAGE_WIDTH, agpf_pkg::CFG_RESET);
        directed_checks();
        phase_items = (TOTAL_ITEMS - cmds_sent) / PHASES;
        if (phase_items < MIN_PHASE_ITEMS) phase_items = MIN_PHASE_ITEMS;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'd0);
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'd0);
                end
                1: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'd511);
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'd511);
                end
                2: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'd1);
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'd256);
                end
                3: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'd256);
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'd1);
                end
                4: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'd16);
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'd7);
                end
                5: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'($urandom_range(1, 300)));
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'($urandom_range(1, 300)));
                end
                6: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'($urandom_range(0, 511)));
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'($urandom_range(0, 511)));
                end
                default: begin
                    write_geometry(agpf_pkg::REG_IMAGE_HEIGHT, 9'd256);
                    write_geometry(agpf_pkg::REG_IMAGE_WIDTH, 9'd256);
                end
            endcase
            // the closing phase runs back to back
            idling_on = (p != PHASES - 1) && ($urandom_range(0, 2) != 0);
            random_phase(phase_items);
        end
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending_sums.size() != 0) begin
            $display("%0t: %0d window sums never arrived", $time, sb.pending_sums.size());
            sb.error_count += sb.pending_sums.size();
        end
        $display("run covered %0d commands and %0d checked window sums", cmds_sent,
                 sb.sums_checked);
        $display("across %0d image size writes, with and without sender idle bursts",
                 geometry_writes);
        if (sb.error_count == 0) begin
            $display("tb_adaptive_gabor_pixel_filter_top passed");
        end else begin
            $display("tb_adaptive_gabor_pixel_filter_top failed");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, block stopped responding", $time);
        $display("tb_adaptive_gabor_pixel_filter_top failed");
        $finish;
    end

endmodule
